@@ sv/cwbf_pkg.sv @@
// Shared types and constants for the clustered weighted box filter.
// No dependencies.
`default_nettype none
package cwbf_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD_CPL = 2'd0,
    CMD_LOAD_PIX = 2'd1,
    CMD_READ     = 2'd2
  } cmd_code_t;

  localparam logic [1:0] REG_HEIGHT   = 2'd0;
  localparam logic [1:0] REG_WIDTH    = 2'd1;
  localparam logic [1:0] REG_CLUSTERS = 2'd2;

  localparam int DIM_W = 7;    // image height / width, row / column
  localparam int KC_W  = 3;    // cluster count
  localparam int PIX_W = 12;   // pixel index field
  localparam int HW_W  = 14;   // height * width
  localparam int S_W   = 34;   // coupling-weighted sum, Q.30
  localparam int WT_W  = 19;   // Wt after >> 15
  localparam int NUM_W = 64;   // numerator of the final ratio

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHK, ST_RCW, ST_WPIX, ST_WTI, ST_WT, ST_WTD, ST_WINI,
    ST_WIN, ST_WIND, ST_MAC, ST_NEXTK, ST_DIVCHK, ST_DIVW, ST_DONE
  } state_t;

  typedef struct packed {
    logic set_zero;
    logic rc_start;
    logic rc_load;
    logic pix_rd;
    logic wt_init;
    logic wt_run;
    logic wt_fin;
    logic win_run;
    logic mac_run;
    logic k_next;
    logic div_start;
    logic div_load;
    logic res_load;
  } cwbf_cmd_t;

  typedef struct packed {
    logic rd_acc;
    logic outside;
    logic div_busy;
    logic wt_last;
    logic win_last;
    logic mac_last;
    logic k_last;
    logic wb_zero;
    logic ch_last;
    logic out_free;
  } cwbf_sts_t;

endpackage
`default_nettype wire

@@ sv/cwbf_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on cwbf_pkg.
`default_nettype none
module cwbf_div import cwbf_pkg::*; #(
  parameter int D_W = 48
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [D_W-1:0]   den,
  output logic                  busy,
  output logic [NUM_W-1:0]      quot,
  output logic [D_W-1:0]        rem
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] nq_r;
  logic [D_W-1:0]   rem_r;
  logic [D_W-1:0]   d_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [D_W:0]     rem_sh;
  logic             ge;
  logic [D_W:0]     rem_sub;

  always_comb begin
    rem_sh  = {rem_r, nq_r[NUM_W-1]};
    ge      = rem_sh >= {1'b0, d_r};
    rem_sub = rem_sh - {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq_r  <= num;
      rem_r <= '0;
      d_r   <= den;
    end else if (busy_r) begin
      nq_r  <= {nq_r[NUM_W-2:0], ge};
      rem_r <= ge ? rem_sub[D_W-1:0] : rem_sh[D_W-1:0];
    end
  end

  assign busy = busy_r;
  assign quot = nq_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

@@ sv/cwbf_datapath.sv @@
// Datapath: config registers, stores, window walk, accumulators, output register.
// Depends on cwbf_pkg and cwbf_div.
`default_nettype none
module cwbf_datapath import cwbf_pkg::*; #(
  parameter int MAX_HEIGHT   = 64,
  parameter int MAX_WIDTH    = 64,
  parameter int MAX_CLUSTERS = 4,
  parameter int RADIUS       = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cwbf_cmd_t        cmd,
  output cwbf_sts_t             sts,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [DIM_W-1:0] cfg_data,
  input  wire logic             in_acc,
  input  wire logic [1:0]       in_cmd,
  input  wire logic [3:0]       coupling_index,
  input  wire logic [15:0]      coupling_value,
  input  wire logic [PIX_W-1:0] pixel_index,
  input  wire logic [63:0]      cluster_weights,
  input  wire logic [47:0]      colors,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output logic [PIX_W-1:0]      result_index,
  output logic [15:0]           out_red,
  output logic [15:0]           out_green,
  output logic [15:0]           out_blue,
  output logic                  zero_weight
);

  localparam int PIXELS = MAX_HEIGHT * MAX_WIDTH;
  localparam int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int QW     = (AW > HW_W) ? AW : HW_W;
  localparam int TD     = MAX_CLUSTERS * MAX_CLUSTERS;
  localparam int CW     = (TD > 1) ? $clog2(TD) : 1;
  localparam int WIN    = (2 * RADIUS + 1) * (2 * RADIUS + 1);
  localparam int NB     = $clog2(WIN + 1);
  localparam int BWW    = 16 + NB;
  localparam int BCW    = 32 + NB;
  localparam int LOW_W  = (BCW + 1) / 2;
  localparam int WBW    = WT_W + BWW + 2;

  // configuration
  logic [DIM_W-1:0] h_reg_r, w_reg_r;
  logic [KC_W-1:0]  k_reg_r;
  logic [DIM_W-1:0] h_eff, w_eff;
  logic [KC_W-1:0]  kc_eff;
  logic [HW_W-1:0]  hw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_reg_r <= 7'd64;
      w_reg_r <= 7'd64;
      k_reg_r <= 3'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEIGHT:   h_reg_r <= cfg_data;
        REG_WIDTH:    w_reg_r <= cfg_data;
        REG_CLUSTERS: k_reg_r <= cfg_data[KC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (h_reg_r == '0) h_eff = DIM_W'(1);
    else if (32'(h_reg_r) > MAX_HEIGHT) h_eff = DIM_W'(MAX_HEIGHT);
    else h_eff = h_reg_r;
    if (w_reg_r == '0) w_eff = DIM_W'(1);
    else if (32'(w_reg_r) > MAX_WIDTH) w_eff = DIM_W'(MAX_WIDTH);
    else w_eff = w_reg_r;
    if (k_reg_r == '0) kc_eff = KC_W'(1);
    else if (32'(k_reg_r) > MAX_CLUSTERS) kc_eff = KC_W'(MAX_CLUSTERS);
    else kc_eff = k_reg_r;
    hw = HW_W'(h_eff) * HW_W'(w_eff);
  end

  // request latch
  logic [PIX_W-1:0] pix_r;
  always_ff @(posedge clk) begin
    if (in_acc && in_cmd == CMD_READ) pix_r <= pixel_index;
  end

  // walk and loop counters
  logic [1:0]       j_r, j_d_r, k_r, dch_r;
  logic             wt_d_r, win_d_r;
  logic [2:0]       m_r;
  logic [DIM_W-1:0] rr_r, cc_r, r0_r, r1_r, c0_r, c1_r;
  logic [QW-1:0]    colbase_r;
  logic [QW-1:0]    q;

  // stores
  logic [15:0] cpl_mem [TD];
  logic [63:0] w_mem [PIXELS];
  logic [47:0] c_mem [PIXELS];
  logic [15:0] cpl_rdata_r;
  logic [63:0] w_rdata_r;
  logic [47:0] c_rdata_r;
  logic        cpl_we, pix_we;
  logic [4:0]  cpl_lin;
  logic [AW-1:0] raddr;

  assign cpl_we  = in_acc && in_cmd == CMD_LOAD_CPL && 32'(coupling_index) < TD;
  assign pix_we  = in_acc && in_cmd == CMD_LOAD_PIX && 32'(pixel_index) < PIXELS;
  assign cpl_lin = 5'(j_r) + 5'(k_r) * 5'(kc_eff);
  assign q       = colbase_r + QW'(rr_r);
  assign raddr   = cmd.pix_rd ? AW'(pix_r) : q[AW-1:0];

  always_ff @(posedge clk) begin
    if (cpl_we) cpl_mem[CW'(coupling_index)] <= coupling_value;
    cpl_rdata_r <= cpl_mem[cpl_lin[CW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (pix_we) begin
      w_mem[AW'(pixel_index)] <= cluster_weights;
      c_mem[AW'(pixel_index)] <= colors;
    end
    w_rdata_r <= w_mem[raddr];
    c_rdata_r <= c_mem[raddr];
  end

  // shared divider: pixel index by height, then the three color ratios
  logic [NUM_W-1:0] div_num, div_quot;
  logic [WBW-1:0]   div_den, div_rem;
  logic             div_busy;
  logic [WBW-1:0]   wb_r;
  logic [NUM_W-1:0] b_r [3];

  assign div_num = cmd.rc_start ? NUM_W'(pix_r) : b_r[dch_r] + NUM_W'(wb_r >> 1);
  assign div_den = cmd.rc_start ? WBW'(h_eff) : wb_r;

  cwbf_div #(.D_W(WBW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.rc_start | cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  // window bounds
  logic [DIM_W-1:0] r0_c, r1_c, c0_c, c1_c;
  always_comb begin
    int row_i, col_i, lo, hi;
    row_i = int'(div_rem[DIM_W-1:0]);
    col_i = int'(div_quot[DIM_W-1:0]);
    lo = row_i - RADIUS;
    hi = row_i + RADIUS;
    r0_c = (lo < 0) ? '0 : DIM_W'(lo);
    r1_c = (hi > int'(h_eff) - 1) ? h_eff - 1'b1 : DIM_W'(hi);
    lo = col_i - RADIUS;
    hi = col_i + RADIUS;
    c0_c = (lo < 0) ? '0 : DIM_W'(lo);
    c1_c = (hi > int'(w_eff) - 1) ? w_eff - 1'b1 : DIM_W'(hi);
  end

  logic [63:0]      pixw_r;
  logic [S_W-1:0]   s_r;
  logic [WT_W-1:0]  wt_r;
  logic [BWW-1:0]   boxw_r;
  logic [BCW-1:0]   boxc_r [3];
  logic [15:0]      wq, wj;
  logic [31:0]      mulc [3];
  logic [31:0]      mulw;
  logic [2:0]       midx;
  logic [1:0]       mch;
  logic [LOW_W-1:0] part;
  logic [WT_W+BWW-1:0]   prod_w;
  logic [WT_W+LOW_W-1:0] prod_c;
  logic [NUM_W-1:0] add_c;

  always_comb begin
    wq   = w_rdata_r[16*k_r +: 16];
    wj   = pixw_r[16*j_d_r +: 16];
    mulw = 32'(wj) * 32'(cpl_rdata_r);
    for (int c = 0; c < 3; c++) mulc[c] = 32'(wq) * 32'(c_rdata_r[16*c +: 16]);
    midx   = m_r - 3'd1;
    mch    = midx[2:1];
    part   = midx[0] ? LOW_W'(boxc_r[mch] >> LOW_W) : boxc_r[mch][LOW_W-1:0];
    prod_w = (WT_W+BWW)'(wt_r) * (WT_W+BWW)'(boxw_r);
    prod_c = (WT_W+LOW_W)'(wt_r) * (WT_W+LOW_W)'(part);
    add_c  = midx[0] ? (NUM_W'(prod_c) << LOW_W) : NUM_W'(prod_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wt_d_r  <= 1'b0;
      win_d_r <= 1'b0;
    end else begin
      wt_d_r  <= cmd.wt_run;
      win_d_r <= cmd.win_run;
    end
  end

  always_ff @(posedge clk) begin
    j_d_r <= j_r;
    if (cmd.rc_load) begin
      r0_r <= r0_c; r1_r <= r1_c; c0_r <= c0_c; c1_r <= c1_c;
      k_r   <= '0;
      dch_r <= '0;
      wb_r  <= '0;
      for (int c = 0; c < 3; c++) b_r[c] <= '0;
    end
    if (cmd.wt_init) begin
      pixw_r <= w_rdata_r;
      s_r    <= '0;
      j_r    <= '0;
    end
    if (cmd.wt_run) j_r <= j_r + 1'b1;
    if (wt_d_r) s_r <= s_r + S_W'(mulw);
    if (cmd.wt_fin) begin
      wt_r      <= s_r[S_W-1:15];
      rr_r      <= r0_r;
      cc_r      <= c0_r;
      colbase_r <= QW'(c0_r) * QW'(h_eff);
      boxw_r    <= '0;
      for (int c = 0; c < 3; c++) boxc_r[c] <= '0;
      m_r       <= '0;
    end
    if (cmd.win_run) begin
      if (rr_r == r1_r) begin
        rr_r      <= r0_r;
        cc_r      <= cc_r + 1'b1;
        colbase_r <= colbase_r + QW'(h_eff);
      end else begin
        rr_r <= rr_r + 1'b1;
      end
    end
    if (win_d_r) begin
      boxw_r <= boxw_r + BWW'(wq);
      for (int c = 0; c < 3; c++) boxc_r[c] <= boxc_r[c] + BCW'(mulc[c]);
    end
    if (cmd.mac_run) begin
      m_r <= m_r + 1'b1;
      if (m_r == 3'd0) wb_r <= wb_r + WBW'(prod_w);
      else b_r[mch] <= b_r[mch] + add_c;
    end
    if (cmd.k_next) k_r <= k_r + 1'b1;
    if (cmd.div_load) dch_r <= dch_r + 1'b1;
  end

  // result holding
  logic [15:0] q_r [3];
  logic        zero_r;
  always_ff @(posedge clk) begin
    if (cmd.rc_start) zero_r <= 1'b0;
    if (cmd.set_zero) begin
      zero_r <= 1'b1;
      for (int c = 0; c < 3; c++) q_r[c] <= '0;
    end
    if (cmd.div_load)
      q_r[dch_r] <= (div_quot > NUM_W'(16'hFFFF)) ? 16'hFFFF : div_quot[15:0];
  end

  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.res_load) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      result_index <= pix_r;
      out_red      <= q_r[0];
      out_green    <= q_r[1];
      out_blue     <= q_r[2];
      zero_weight  <= zero_r;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    sts.rd_acc   = in_acc && in_cmd == CMD_READ;
    sts.outside  = HW_W'(pix_r) >= hw;
    sts.div_busy = div_busy;
    sts.wt_last  = KC_W'(j_r) == kc_eff - 1'b1;
    sts.win_last = rr_r == r1_r && cc_r == c1_r;
    sts.mac_last = m_r == 3'd6;
    sts.k_last   = KC_W'(k_r) == kc_eff - 1'b1;
    sts.wb_zero  = wb_r == '0;
    sts.ch_last  = dch_r == 2'd2;
    sts.out_free = !out_valid_r || out_ready;
  end

endmodule
`default_nettype wire

@@ sv/cwbf_ctrl.sv @@
// Sequencer for the read operation: steps the datapath through each cluster.
// Depends on cwbf_pkg.
`default_nettype none
module cwbf_ctrl import cwbf_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cwbf_sts_t sts,
  output cwbf_cmd_t      cmd,
  output logic           in_ready
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (sts.rd_acc) state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (sts.outside) begin
          cmd.set_zero = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          cmd.rc_start = 1'b1;
          state_nxt = ST_RCW;
        end
      end
      ST_RCW: begin
        if (!sts.div_busy) begin
          cmd.rc_load = 1'b1;
          state_nxt = ST_WPIX;
        end
      end
      ST_WPIX: begin
        cmd.pix_rd = 1'b1;
        state_nxt = ST_WTI;
      end
      ST_WTI: begin
        cmd.wt_init = 1'b1;
        state_nxt = ST_WT;
      end
      ST_WT: begin
        cmd.wt_run = 1'b1;
        if (sts.wt_last) state_nxt = ST_WTD;
      end
      ST_WTD: state_nxt = ST_WINI;   // last coupling product lands
      ST_WINI: begin
        cmd.wt_fin = 1'b1;
        state_nxt = ST_WIN;
      end
      ST_WIN: begin
        cmd.win_run = 1'b1;
        if (sts.win_last) state_nxt = ST_WIND;
      end
      ST_WIND: state_nxt = ST_MAC;   // last window sample lands
      ST_MAC: begin
        cmd.mac_run = 1'b1;
        if (sts.mac_last) state_nxt = ST_NEXTK;
      end
      ST_NEXTK: begin
        cmd.k_next = 1'b1;
        state_nxt = sts.k_last ? ST_DIVCHK : ST_WPIX;
      end
      ST_DIVCHK: begin
        if (sts.wb_zero) begin
          cmd.set_zero = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt = ST_DIVW;
        end
      end
      ST_DIVW: begin
        if (!sts.div_busy) begin
          cmd.div_load = 1'b1;
          state_nxt = sts.ch_last ? ST_DONE : ST_DIVCHK;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ sv/clustered_weighted_box_filter.sv @@
// Clustered weighted box filter, top level.
// Depends on cwbf_pkg, cwbf_ctrl, cwbf_datapath.
//
// Input stream: tuser carries the command (load coupling entry, load pixel,
// read filtered pixel); tdata carries the load and read fields. Loads give
// no result. A read gives one result transaction.
// Configuration (height, width, cluster count) is written on the cfg
// channel, always ready; the user must write it only while no read is in
// flight, which the block itself does not enforce. A read first splits the
// index into row and column on the shared bit-serial divider, then per
// cluster walks the N window pixels inside the image (at most
// (2*RADIUS+1)^2, one store read per cycle), then runs the divider once
// per color channel. A read outside the image, or with zero total weight,
// ends early with zero_weight set.
// A read is taken only when the previous one has finished; a finished
// result waits in the output register while the next item is accepted.
// If the receiver stalls, the next read holds in its final state until the
// output register frees. Reset clears control and registers to 64, 64, 4;
// store contents are undefined until loaded.
`default_nettype none
module clustered_weighted_box_filter import cwbf_pkg::*; #(
  parameter int MAX_HEIGHT   = 64,
  parameter int MAX_WIDTH    = 64,
  parameter int MAX_CLUSTERS = 4,
  parameter int RADIUS       = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // coupling_index[3:0], coupling_value[19:4], pixel_index[31:20],
  // cluster_weights[95:32], color_red[111:96], color_green[127:112],
  // color_blue[143:128]
  input  wire logic [143:0] in_tdata,
  // command[1:0]
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // result_index[11:0], out_red[27:12], out_green[43:28], out_blue[59:44], zero pad
  output logic [63:0]       out_tdata,
  // zero_weight[0]
  output logic [0:0]        out_tuser,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [6:0]   cfg_data
);

  cwbf_cmd_t cmd;
  cwbf_sts_t sts;
  logic [PIX_W-1:0] res_idx;
  logic [15:0] r, g, b;
  logic zw;

  assign cfg_ready = 1'b1;

  cwbf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_tready)
  );

  cwbf_datapath #(
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .RADIUS       (RADIUS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_valid & cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_acc          (in_tvalid & in_tready),
    .in_cmd          (in_tuser),
    .coupling_index  (in_tdata[3:0]),
    .coupling_value  (in_tdata[19:4]),
    .pixel_index     (in_tdata[31:20]),
    .cluster_weights (in_tdata[95:32]),
    .colors          (in_tdata[143:96]),
    .out_ready       (out_tready),
    .out_valid       (out_tvalid),
    .result_index    (res_idx),
    .out_red         (r),
    .out_green       (g),
    .out_blue        (b),
    .zero_weight     (zw)
  );

  assign out_tdata = {4'b0, b, g, r, res_idx};
  assign out_tuser = zw;

endmodule
`default_nettype wire
